[hdl/nla_pkg.sv]
// Package for the nearest landmark association unit.
// Word types, field widths, function and status codes shared by all modules.
// No dependencies.
`default_nettype none

package nla_pkg;

  localparam int COORD_W = 20;
  localparam int ID_W    = 10;
  localparam int DIST_W  = 42;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;

  // Function codes of an input word
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

  // Status codes of a result word
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [ID_W-1:0]           landmark_id;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   matched_id;
    logic [DIST_W-1:0] min_dist_sq;
    logic [STAT_W-1:0] status;
  } out_word_t;

  // One stored landmark
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ID_W-1:0]           id;
  } lm_entry_t;

  // Control from the sequencer to the distance unit
  typedef struct packed {
    logic start;
    logic vld;
  } dist_ctrl_t;

  // Running best match held by the distance unit
  typedef struct packed {
    logic [DIST_W-1:0] dsq;
    logic [ID_W-1:0]   id;
  } dist_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE,
    S_HOLD
  } nla_state_t;

endpackage

`default_nettype wire

[hdl/nla_cell.sv]
// One cell of the landmark chain: holds a single landmark entry.
// Loads a new entry on append, otherwise takes its neighbour's entry on rotate.
// Depends on nla_pkg.
`default_nettype none

module nla_cell
  import nla_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      wr_en,
  input  wire logic      shift_en,
  input  wire lm_entry_t wr_entry,
  input  wire lm_entry_t nbr_entry,
  output lm_entry_t      q
);

  lm_entry_t entry_r;

  // Load on append, rotate during a scan, hold otherwise
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end else if (shift_en) begin
      entry_r <= nbr_entry;
    end
  end

  assign q = entry_r;

endmodule

`default_nettype wire

[hdl/nla_dist.sv]
// Squared distance and running minimum for the landmark at the chain head.
// Three stages: absolute difference, squares, sum and compare.
// Depends on nla_pkg.
`default_nettype none

module nla_dist
  import nla_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dist_ctrl_t                ctrl,
  input  wire logic signed [COORD_W-1:0] obs_x,
  input  wire logic signed [COORD_W-1:0] obs_y,
  input  wire lm_entry_t                 lm,
  output dist_res_t                      res
);

  logic signed [COORD_W:0] dx, dy, ndx, ndy;
  logic [COORD_W-1:0]      adx, ady;
  logic [COORD_W-1:0]      adx_r, ady_r;
  logic [SQ_W-1:0]         sqx_r, sqy_r;
  logic [ID_W-1:0]         id1_r, id2_r;
  logic                    v1_r, v2_r;
  logic [DIST_W-1:0]       sum;
  logic [DIST_W-1:0]       best_r;
  logic [ID_W-1:0]         best_id_r;

  // Stage 1: exact differences and their magnitudes
  always_comb begin
    dx  = (COORD_W+1)'(obs_x) - (COORD_W+1)'(lm.x);
    dy  = (COORD_W+1)'(obs_y) - (COORD_W+1)'(lm.y);
    ndx = -dx;
    ndy = -dy;
    adx = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
    ady = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
  end

  // Valid flags for the two pipeline stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.vld;
      v2_r <= v1_r;
    end
  end

  // Stage registers: magnitudes, then squares
  always_ff @(posedge clk) begin
    adx_r <= adx;
    ady_r <= ady;
    id1_r <= lm.id;
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
    id2_r <= id1_r;
  end

  assign sum = DIST_W'(sqx_r) + DIST_W'(sqy_r);

  // Keep the strictly smaller distance so the earliest entry wins a tie
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      best_r    <= '1;
      best_id_r <= '0;
    end else if (v2_r && (sum < best_r)) begin
      best_r    <= sum;
      best_id_r <= id2_r;
    end
  end

  assign res.dsq = best_r;
  assign res.id  = best_id_r;

endmodule

`default_nettype wire

[hdl/nearest_landmark_association_unit.sv]
// Nearest landmark association unit.
// Input channel (in_valid / in_stall / in_word) carries one word per command:
// clear the table, append a landmark, or query with an observation point.
// Result channel (out_valid / out_stall / out_word) returns exactly one word
// per command: matched id, squared distance (unsigned Q42.0) and status.
// Landmarks live in a ring of MAX_LANDMARKS cells; a query rotates the ring
// once through a single three-stage distance unit at its head.
// Clear, append and an empty query are answered straight from the idle state.
// A query on a non-empty table runs the full ring rotation, then drains the
// distance pipeline; one command is in flight at a time.
// The output register frees the input side: a new command is taken while
// the previous result waits. If that result is still stalled when the next
// one is ready, the next result is parked and input is stalled until the
// receiver takes the waiting word.
// Reset empties the table and the output register; the landmark cells
// themselves are not cleared.
// Depends on nla_pkg, nla_cell, nla_dist.
`default_nettype none

module nearest_landmark_association_unit
  import nla_pkg::*;
#(
  parameter int MAX_LANDMARKS = 64
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
  localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LANDMARKS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LANDMARKS - 1);

  nla_state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]           scan_k_r, scan_k_nxt;
  logic                       drain_r, drain_nxt;
  logic signed [COORD_W-1:0]  obs_x_r, obs_y_r;
  out_word_t                  res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_word_t                  out_word_r, out_word_nxt;

  logic                       in_acc;
  logic                       out_free;
  logic                       out_load;
  out_word_t                  load_word;
  logic                       append_we;
  dist_ctrl_t                 dctrl;
  dist_res_t                  dres;
  lm_entry_t                  wr_entry;
  lm_entry_t                  cell_q [MAX_LANDMARKS];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign wr_entry.x  = in_word.pos_x;
  assign wr_entry.y  = in_word.pos_y;
  assign wr_entry.id = in_word.landmark_id;

  // Ring of landmark cells; each takes its upper neighbour, the last wraps to the head
  for (genvar i = 0; i < MAX_LANDMARKS; i++) begin : g_cell
    nla_cell u_cell (
      .clk       (clk),
      .wr_en     (append_we && (count_r == CNT_W'(i))),
      .shift_en  (state_r == S_SCAN),
      .wr_entry  (wr_entry),
      .nbr_entry (cell_q[(i + 1) % MAX_LANDMARKS]),
      .q         (cell_q[i])
    );
  end

  nla_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dctrl),
    .obs_x (obs_x_r),
    .obs_y (obs_y_r),
    .lm    (cell_q[0]),
    .res   (dres)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_k_r    <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_k_r    <= scan_k_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      obs_x_r <= in_word.pos_x;
      obs_y_r <= in_word.pos_y;
    end
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // Sequencer: decode the command, run the scan, hand the result word out
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    scan_k_nxt  = scan_k_r;
    drain_nxt   = drain_r;
    res_nxt     = res_r;
    out_load    = 1'b0;
    load_word   = '0;
    append_we   = 1'b0;
    dctrl.start = 1'b0;
    dctrl.vld   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load_word.status = ST_OK;
          case (in_word.func)
            FN_CLEAR: begin
              count_nxt = '0;
            end
            FN_APPEND: begin
              if (count_r == CNT_MAX) begin
                load_word.status = ST_FULL;
              end else begin
                append_we = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FN_QUERY: begin
              if (count_r == '0) begin
                load_word.status = ST_EMPTY;
              end else begin
                dctrl.start = 1'b1;
                scan_k_nxt  = '0;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
          // Immediate results go out now, or park until the output frees
          if (state_nxt == S_IDLE) begin
            if (out_free) begin
              out_load = 1'b1;
            end else begin
              res_nxt   = load_word;
              state_nxt = S_HOLD;
            end
          end
        end
      end
      S_SCAN: begin
        dctrl.vld = (CNT_W'(scan_k_r) < count_r);
        if (scan_k_r == IDX_LAST) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end else begin
          scan_k_nxt = scan_k_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // Let the last entry pass the squares and compare stages
        if (drain_r) begin
          state_nxt = S_DONE;
        end else begin
          drain_nxt = 1'b1;
        end
      end
      S_DONE: begin
        load_word.matched_id  = dres.id;
        load_word.min_dist_sq = dres.dsq;
        load_word.status      = ST_OK;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          res_nxt   = load_word;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        load_word = res_r;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load a new word, drop it once taken
  always_comb begin
    out_word_nxt = out_load ? load_word : out_word_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Table fill never passes its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("entry count above capacity");

  // A dropped append leaves the table as it was
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_word.func == FN_APPEND) && (count_r == CNT_MAX))
      |=> (count_r == CNT_MAX))
    else $error("append to full table changed the count");

  // Clear empties the table
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_word.func == FN_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the table");

  // A scan ends after the last ring position
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && (scan_k_r == IDX_LAST)) |=> (state_r == S_DRAIN))
    else $error("scan did not end after one rotation");

  // A finished query with a free output is presented next cycle
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free) |=> out_valid_r)
    else $error("query result not presented");

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for nearest_landmark_association_unit: clear, append and query words
// are checked against a behavioural landmark table held here. Depends on nla_pkg
// and the unit's RTL only.
`timescale 1ns / 100ps

module tb;
  import nla_pkg::*;

  localparam int MAX_LM     = 64;
  localparam int RUN_LIMIT  = 200000;
  localparam int LONG_HOLD  = 300;
  localparam int CALM_TAIL  = 50;
  localparam int DRAIN_WAIT = 120;
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MAX = 20'sh7FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 20'sh80000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  nearest_landmark_association_unit #(.MAX_LANDMARKS(MAX_LM)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // Command words waiting to be sent, and match words still owed by the unit
  in_word_t  commands_todo[$];
  out_word_t matches_due[$];
  out_word_t got_due;

  // Landmark table as the unit should hold it
  logic signed [COORD_W-1:0] lm_x [MAX_LM];
  logic signed [COORD_W-1:0] lm_y [MAX_LM];
  logic [ID_W-1:0]           lm_id [MAX_LM];
  int                        lm_count = 0;

  // Positions appended by the generator, used to aim queries and make ties
  logic signed [COORD_W-1:0] near_x[$];
  logic signed [COORD_W-1:0] near_y[$];

  int  n_cmds = 0;
  int  n_total = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  fails = 0;
  int  cycles = 0;
  logic in_took = 1'b0;
  logic calm = 1'b0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;

  // Exact squared distance, unsigned Q42.0
  function automatic logic [DIST_W-1:0] dist_sq(input logic signed [COORD_W-1:0] ax,
                                                input logic signed [COORD_W-1:0] ay,
                                                input logic signed [COORD_W-1:0] bx,
                                                input logic signed [COORD_W-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return DIST_W'(dx * dx + dy * dy);
  endfunction

  // Apply one command to the table and return the match word it should give
  function automatic out_word_t predict_match(input in_word_t w);
    out_word_t r;
    logic [DIST_W-1:0] d;
    r = '0;
    r.status = ST_OK;
    case (w.func)
      FN_CLEAR: lm_count = 0;
      FN_APPEND: begin
        if (lm_count >= MAX_LM) begin
          r.status = ST_FULL;
        end else begin
          lm_x[lm_count]  = w.pos_x;
          lm_y[lm_count]  = w.pos_y;
          lm_id[lm_count] = w.landmark_id;
          lm_count++;
        end
      end
      FN_QUERY: begin
        if (lm_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.min_dist_sq = dist_sq(w.pos_x, w.pos_y, lm_x[0], lm_y[0]);
          r.matched_id  = lm_id[0];
          // strict less-than keeps the earliest entry on a tie
          for (int k = 1; k < lm_count; k++) begin
            d = dist_sq(w.pos_x, w.pos_y, lm_x[k], lm_y[k]);
            if (d < r.min_dist_sq) begin
              r.min_dist_sq = d;
              r.matched_id  = lm_id[k];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return C_MAX;
      1: return C_MIN;
      4: return COORD_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic push_cmd(input logic [FUNC_W-1:0] f, input logic signed [COORD_W-1:0] x,
                          input logic signed [COORD_W-1:0] y, input logic [ID_W-1:0] id);
    in_word_t w;
    w.func = f;
    w.pos_x = x;
    w.pos_y = y;
    w.landmark_id = id;
    commands_todo.insert(commands_todo.size(), w);
    if (f != FN_SPARE) n_cmds++;
  endtask

  // Query near a known landmark half the time, anywhere otherwise
  task automatic push_query();
    int j;
    if (near_x.size() > 0 && $urandom_range(0, 1) == 0) begin
      j = $urandom_range(0, near_x.size() - 1);
      push_cmd(FN_QUERY, near_x[j] + COORD_W'(int'($urandom_range(0, 8)) - 4),
               near_y[j] + COORD_W'(int'($urandom_range(0, 8)) - 4), ID_W'($urandom));
    end else begin
      push_cmd(FN_QUERY, rand_coord(), rand_coord(), ID_W'($urandom));
    end
  endtask

  // Append a landmark, sometimes on top of an earlier one to force a tie
  task automatic push_landmark();
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    int j;
    if (near_x.size() > 0 && $urandom_range(0, 3) == 0) begin
      j = $urandom_range(0, near_x.size() - 1);
      x = near_x[j];
      y = near_y[j];
    end else begin
      x = rand_coord();
      y = rand_coord();
    end
    near_x.insert(near_x.size(), x);
    near_y.insert(near_y.size(), y);
    push_cmd(FN_APPEND, x, y, ID_W'($urandom));
  endtask

  // Stimulus, reset and end of run
  initial begin
    int n_lm;
    logic first_fill;
    logic [FUNC_W-1:0] f;

    // directed: empty query, extreme corners, tie, spare code, clear
    push_cmd(FN_QUERY, C_MAX, C_MIN, 10'h3FF);
    push_cmd(FN_APPEND, C_MAX, C_MAX, 10'h3FF);
    push_cmd(FN_QUERY, C_MIN, C_MIN, 10'h000);
    push_cmd(FN_APPEND, C_MIN, C_MIN, 10'h000);
    push_cmd(FN_QUERY, '0, '0, 10'h155);
    push_cmd(FN_QUERY, C_MAX, C_MIN, 10'h2AA);
    push_cmd(FN_APPEND, C_MAX, C_MAX, 10'h005);
    push_cmd(FN_QUERY, C_MAX, C_MAX, 10'h3FF);
    push_cmd(FN_APPEND, 20'sh00100, 20'sh00000, 10'h011);
    push_cmd(FN_APPEND, 20'shFFF00, 20'sh00000, 10'h022);
    push_cmd(FN_QUERY, '0, '0, 10'h000);
    push_cmd(FN_SPARE, C_MAX, C_MIN, 10'h3FF);
    push_cmd(FN_QUERY, 20'sh00001, 20'shFFFFF, 10'h000);
    push_cmd(FN_CLEAR, C_MIN, C_MAX, 10'h3FF);
    push_cmd(FN_QUERY, '0, '0, 10'h000);
    push_cmd(FN_APPEND, 20'sh12345, 20'shEDCBA, 10'h2AA);
    push_cmd(FN_QUERY, 20'sh12345, 20'shEDCBA, 10'h155);
    push_cmd(FN_CLEAR, '0, '0, 10'h000);

    // random: mostly clear / fill / query sequences, some noise
    first_fill = 1'b1;
    while (n_cmds < 420) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          f = FUNC_W'($urandom_range(0, 3));
          push_cmd(f, rand_coord(), rand_coord(), ID_W'($urandom));
        end
      end else begin
        push_cmd(FN_CLEAR, rand_coord(), rand_coord(), ID_W'($urandom));
        near_x.delete();
        near_y.delete();
        if (first_fill) n_lm = MAX_LM + 2;
        else if ($urandom_range(0, 4) == 0) n_lm = $urandom_range(40, MAX_LM + 6);
        else n_lm = $urandom_range(1, 10);
        first_fill = 1'b0;
        for (int k = 0; k < n_lm; k++) begin
          push_landmark();
          if ($urandom_range(0, 7) == 0) push_query();
        end
        repeat ($urandom_range(1, 5)) push_query();
      end
    end
    n_total = commands_todo.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_in != n_total || matches_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fails == 0) begin
      $display("** nearest_landmark_association_unit: PASSED **");
    end else begin
      $display("** nearest_landmark_association_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("** nearest_landmark_association_unit: FAILED **");
      $finish;
    end
  end

  // Monitor: predict on each accepted command, check each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        matches_due.insert(matches_due.size(), predict_match(in_word));
        words_in++;
        calm <= (words_in >= n_total - CALM_TAIL);
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (matches_due.size() == 0) begin
          $error("result word with nothing expected: id %0d dist %0d status %0d",
                 out_word.matched_id, out_word.min_dist_sq, out_word.status);
          fails++;
        end else begin
          got_due = matches_due.pop_front();
          if (out_word.matched_id !== got_due.matched_id) begin
            $error("matched_id: expected %0d, got %0d", got_due.matched_id,
                   out_word.matched_id);
            fails++;
          end
          if (out_word.min_dist_sq !== got_due.min_dist_sq) begin
            $error("min_dist_sq: expected %0d, got %0d", got_due.min_dist_sq,
                   out_word.min_dist_sq);
            fails++;
          end
          if (out_word.status !== got_due.status) begin
            $error("status: expected %0d, got %0d", got_due.status, out_word.status);
            fails++;
          end
        end
      end
    end
  end

  // Driver: hold a word until taken, then advance, with bursts of idle cycles
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (commands_todo.size() > 0) begin
          in_word  <= commands_todo.pop_front();
          in_valid <= 1'b1;
          if (!calm && ((words_in / 40) % 3 != 2) && $urandom_range(0, 5) == 0)
            src_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off to fill the unit, then random stall bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && words_out >= 40) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && ((words_out / 30) % 3 != 1) && $urandom_range(0, 7) == 0)
          sink_gap = $urandom_range(1, 12);
      end
    end
  end

endmodule
